FILE: rtl/slma_pkg.sv
// shared types, constants and threshold rom for the sound level meter alarm
`default_nettype none
package slma_pkg;

    localparam int WINDOW_SAMPLES = 10;
    localparam int TABLE_DEPTH    = 100;
    localparam int ROM_SIZE       = 100;

    localparam int COUNT_W = 24;
    localparam int LEVEL_W = 7;
    localparam int THR_W   = 14;
    localparam int FILL_W  = 4;
    localparam int SUM_W   = 28;
    localparam int AVG_W   = 16;
    localparam int TOG_W   = 8;
    localparam int PROD_W  = AVG_W + FILL_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE = 2'd2;

    localparam logic [LEVEL_W-1:0] LIMIT_RESET  = 7'd0;
    localparam logic [AVG_W-1:0]   AVG_RESET    = 16'd52;
    localparam logic [TOG_W-1:0]   TOGGLE_RESET = 8'd200;

    localparam logic KIND_MEASURE = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    localparam logic [THR_W-1:0] LEVEL_ROM [ROM_SIZE] = '{
        14'd4, 14'd5, 14'd6, 14'd7, 14'd8, 14'd9, 14'd9, 14'd9, 14'd9, 14'd10,
        14'd10, 14'd10, 14'd11, 14'd11, 14'd12, 14'd12, 14'd13, 14'd13, 14'd14, 14'd14,
        14'd15, 14'd16, 14'd16, 14'd17, 14'd19, 14'd21, 14'd23, 14'd26, 14'd29, 14'd34,
        14'd40, 14'd46, 14'd52, 14'd60, 14'd69, 14'd79, 14'd91, 14'd103, 14'd117, 14'd131,
        14'd146, 14'd162, 14'd176, 14'd192, 14'd209, 14'd227, 14'd247, 14'd278, 14'd301,
        14'd336,
        14'd363, 14'd392, 14'd424, 14'd458, 14'd494, 14'd534, 14'd577, 14'd623, 14'd673,
        14'd726,
        14'd785, 14'd848, 14'd915, 14'd988, 14'd1068, 14'd1153, 14'd1245, 14'd1345,
        14'd1453, 14'd1569,
        14'd1694, 14'd1830, 14'd1976, 14'd2135, 14'd2305, 14'd2490, 14'd2689, 14'd2904,
        14'd3137, 14'd3388,
        14'd3659, 14'd3951, 14'd4268, 14'd4609, 14'd4978, 14'd5376, 14'd5806, 14'd6271,
        14'd6772, 14'd7314,
        14'd7899, 14'd8531, 14'd9214, 14'd9951, 14'd10747, 14'd11607, 14'd12536, 14'd13538,
        14'd14622, 14'd15791
    };

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
    } slma_search_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } slma_search_rsp_t;

    function automatic logic [THR_W-1:0] rom_entry(input logic [LEVEL_W-1:0] idx);
        logic [THR_W-1:0] val;
        if (int'(idx) < ROM_SIZE)
            val = LEVEL_ROM[idx];
        else
            val = LEVEL_ROM[ROM_SIZE-1];
        return val;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/slma_classifier.sv
// iterative threshold search, one rom entry compared per cycle
`default_nettype none
module slma_classifier
    import slma_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire slma_search_req_t req,
    output slma_search_rsp_t      rsp
);

    localparam logic [LEVEL_W-1:0] LAST_IDX = LEVEL_W'(TABLE_DEPTH - 1);

    logic               busy_reg, busy_next;
    logic [LEVEL_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               advance;

    // shared compare unit
    assign advance = (idx_reg < LAST_IDX) &&
                     (count_reg > {{(COUNT_W-THR_W){1'b0}}, rom_entry(idx_reg)});

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            idx_next   = '0;
            count_next = req.count;
        end
        else if (busy_reg)
        begin
            if (advance)
                idx_next = idx_reg + LEVEL_W'(1);
            else
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign rsp.done  = busy_reg && !advance;
    assign rsp.level = idx_reg;

endmodule
`default_nettype wire

FILE: rtl/sound_level_meter_alarm.sv
// top level of the sound level meter alarm
//
// channel  dir  handshake                 payload
// s_axis   in   s_tvalid / s_tready       s_tuser = kind, s_tdata = pulse_count
// m_axis   out  m_tvalid / m_tready       m_tdata = level, over_limit, buzzer, alarm
// cfg      in   cfg_we                    cfg_index, cfg_data
//
// a nonzero measurement runs the linear rom search (one threshold compared per cycle)
// before its write step; ticks and zero counts go straight to the write step
// rst_n resets control state asynchronously; config registers return to reset values
// s_tready is high only while idle; a result waits in the output register and the
// next item is taken meanwhile, but its write step stalls until m_tready frees it
`default_nettype none
module sound_level_meter_alarm
    import slma_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [COUNT_W-1:0]    s_tdata,   // [23:0] pulse_count
    input  wire logic                  s_tuser,   // [0] kind
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [6:0] level_index, [7] over_limit,
                                                  // [8] buzzer, [9] window_alarm
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_WRITE  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               kind_reg, kind_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LEVEL_W-1:0] found_reg, found_next;

    logic [LEVEL_W-1:0] limit_reg;
    logic [AVG_W-1:0]   avg_reg;
    logic [TOG_W-1:0]   toggle_period_reg;

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [TOG_W-1:0]   toggle_count_reg, toggle_count_next;
    logic               buzzer_reg, buzzer_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    slma_search_req_t   search_req;
    slma_search_rsp_t   search_rsp;

    logic               accept;
    logic               out_free;
    logic               write_fire;
    logic [SUM_W-1:0]   sum_add;
    logic [FILL_W-1:0]  fill_add;
    logic [PROD_W-1:0]  thr_times_n;
    logic [TOG_W-1:0]   tog_inc;
    logic               alarm;
    logic               over;

    slma_classifier u_classifier (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (search_req),
        .rsp   (search_rsp)
    );

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign write_fire = (state_reg == S_WRITE) && out_free;

    assign search_req.start = accept && (s_tuser == KIND_MEASURE) && (s_tdata != '0);
    assign search_req.count = s_tdata;

    assign sum_add     = sum_reg + {{(SUM_W-COUNT_W){1'b0}}, count_reg};
    assign fill_add    = fill_reg + FILL_W'(1);
    assign thr_times_n = PROD_W'(avg_reg) * PROD_W'(WINDOW_SAMPLES);
    assign tog_inc     = toggle_count_reg + TOG_W'(1);

    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        count_next        = count_reg;
        found_next        = found_reg;
        level_next        = level_reg;
        toggle_count_next = toggle_count_reg;
        buzzer_next       = buzzer_reg;
        fill_next         = fill_reg;
        sum_next          = sum_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        alarm             = 1'b0;
        over              = 1'b0;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = s_tuser;
                    count_next = s_tdata;
                    state_next = search_req.start ? S_SEARCH : S_WRITE;
                end
            end
            S_SEARCH:
            begin
                if (search_rsp.done)
                begin
                    found_next = search_rsp.level;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    if (kind_reg == KIND_MEASURE)
                    begin
                        if (int'(fill_add) >= WINDOW_SAMPLES)
                        begin
                            alarm     = (sum_add >= SUM_W'(thr_times_n));
                            fill_next = '0;
                            sum_next  = '0;
                        end
                        else
                        begin
                            fill_next = fill_add;
                            sum_next  = sum_add;
                        end
                        if (count_reg != '0)
                            level_next = found_reg;
                    end
                    else
                    begin
                        if (level_reg >= limit_reg)
                        begin
                            if (tog_inc > toggle_period_reg)
                            begin
                                toggle_count_next = '0;
                                buzzer_next       = !buzzer_reg;
                            end
                            else
                                toggle_count_next = tog_inc;
                        end
                        else
                            buzzer_next = 1'b1;
                    end
                    over         = (level_next >= limit_reg);
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, alarm, buzzer_next, over, level_next};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            level_reg         <= '0;
            toggle_count_reg  <= '0;
            buzzer_reg        <= 1'b1;
            fill_reg          <= '0;
            sum_reg           <= '0;
            m_valid_reg       <= 1'b0;
            limit_reg         <= LIMIT_RESET;
            avg_reg           <= AVG_RESET;
            toggle_period_reg <= TOGGLE_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            level_reg        <= level_next;
            toggle_count_reg <= toggle_count_next;
            buzzer_reg       <= buzzer_next;
            fill_reg         <= fill_next;
            sum_reg          <= sum_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LIMIT:  limit_reg         <= cfg_data[LEVEL_W-1:0];
                    CFG_AVG:    avg_reg           <= cfg_data[AVG_W-1:0];
                    CFG_TOGGLE: toggle_period_reg <= cfg_data[TOG_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        count_reg  <= count_next;
        found_reg  <= found_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_fill_below_window: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) < WINDOW_SAMPLES)
        else $error("window fill reached window length");

    a_level_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        int'(level_reg) < TABLE_DEPTH)
        else $error("level beyond table");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("item taken while busy");

    a_write_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        write_fire |=> m_tvalid)
        else $error("result not presented");

    a_search_done_only_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        search_rsp.done |-> (state_reg == S_SEARCH))
        else $error("search finished outside search state");

endmodule
`default_nettype wire
